[rtl/ptd_pkg.sv]
// shared types and constants for the pid temperature duty block
// no dependencies; used by every other rtl file but ptd_checker through scoped names
`default_nettype none
package ptd_pkg;

    // converter to percent scaling: trunc(100*(s-205)/409)
    localparam logic signed [10:0] SCALE_OFFSET = 11'sd205;
    localparam logic [33:0]        PCT_RECIP    = 34'd16408100;  // 100*ceil(2^26/409)
    localparam int                 PCT_SHIFT    = 26;

    // duty scaling: trunc(p/100)
    localparam logic [34:0] DUTY_RECIP = 35'd167773;              // ceil(2^24/100)
    localparam int          DUTY_SHIFT = 24;

    localparam logic [6:0] PERCENT_FULL = 7'd100;
    localparam int         FRAC_BITS    = 12;

    // register map, word index
    localparam logic [2:0] REG_KP           = 3'd0;
    localparam logic [2:0] REG_KI_Q12       = 3'd1;
    localparam logic [2:0] REG_KD           = 3'd2;
    localparam logic [2:0] REG_WINDUP_LIMIT = 3'd3;
    localparam logic [2:0] REG_DUTY_FULL    = 3'd4;

    localparam logic [7:0]  KP_RESET           = 8'd12;
    localparam logic [11:0] KI_Q12_RESET       = 12'd410;
    localparam logic [7:0]  KD_RESET           = 8'd40;
    localparam logic [14:0] WINDUP_LIMIT_RESET = 15'd16000;
    localparam logic [9:0]  DUTY_FULL_RESET    = 10'd621;

    typedef logic signed [8:0] error_t;

    typedef struct packed {
        logic signed [17:0] p_term;
        logic signed [18:0] d_term;
        logic signed [28:0] i_term;
    } terms_t;

endpackage
`default_nettype wire

[rtl/ptd_scale.sv]
// converts both converter samples to percent and forms the control error
// depends on ptd_pkg
`default_nettype none
module ptd_scale (
    input  wire logic [9:0]      measured_sample,
    input  wire logic [9:0]      setpoint_sample,
    output ptd_pkg::error_t      error_pct
);

    function automatic logic signed [8:0] to_percent(input logic [9:0] s);
        logic signed [10:0] d;
        logic [9:0]         mag;
        logic [33:0]        prod;
        logic [7:0]         q;
        d    = $signed({1'b0, s}) - ptd_pkg::SCALE_OFFSET;
        mag  = d[10] ? 10'(-d) : d[9:0];
        prod = 34'(mag) * ptd_pkg::PCT_RECIP;
        q    = prod[ptd_pkg::PCT_SHIFT+7:ptd_pkg::PCT_SHIFT];
        return d[10] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    logic signed [8:0] meas_pct;
    logic signed [8:0] setp_pct;
    logic signed [9:0] diff;

    always_comb begin
        meas_pct  = to_percent(measured_sample);
        setp_pct  = to_percent(setpoint_sample);
        diff      = {setp_pct[8], setp_pct} - {meas_pct[8], meas_pct};
        error_pct = diff[8:0];
    end

endmodule
`default_nettype wire

[rtl/ptd_law.sv]
// control law state: integral with conditional integration and previous error,
// forms the three gain products; depends on ptd_pkg
`default_nettype none
module ptd_law (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ptd_pkg::error_t  error_pct,
    input  wire logic             update,
    input  wire logic [7:0]       kp,
    input  wire logic [11:0]      ki_q12,
    input  wire logic [7:0]       kd,
    input  wire logic [14:0]      windup_limit,
    output ptd_pkg::terms_t       terms
);

    logic signed [15:0] integral_reg;
    logic signed [15:0] integral_next;
    logic signed [8:0]  prev_err_reg;

    logic signed [16:0] int_ext;
    logic [16:0]        int_mag;
    logic signed [16:0] int_sum;
    logic signed [15:0] int_sat;
    logic signed [9:0]  err_diff;

    always_comb begin
        int_ext = {integral_reg[15], integral_reg};
        int_mag = int_ext[16] ? 17'(-int_ext) : int_ext;
        int_sum = int_ext + {{8{error_pct[8]}}, error_pct};
        if (int_sum[16] != int_sum[15]) begin
            int_sat = int_sum[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            int_sat = int_sum[15:0];
        end
        integral_next = (int_mag < {2'b00, windup_limit}) ? int_sat : integral_reg;
        err_diff      = {error_pct[8], error_pct} - {prev_err_reg[8], prev_err_reg};

        terms.p_term = $signed({1'b0, kp}) * error_pct;
        terms.d_term = $signed({1'b0, kd}) * err_diff;
        terms.i_term = $signed({1'b0, ki_q12}) * integral_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end else if (update) begin
            integral_reg <= integral_next;
            prev_err_reg <= error_pct;
        end
    end

endmodule
`default_nettype wire

[rtl/ptd_drive.sv]
// sums the gain products in 1/4096 units, truncates and clamps to 0..100
// depends on ptd_pkg
`default_nettype none
module ptd_drive (
    input  wire ptd_pkg::terms_t  terms,
    output logic [6:0]            drive_percent
);

    logic signed [17:0] p_term;
    logic signed [18:0] d_term;
    logic signed [32:0] i_ext;
    logic signed [19:0] pd_sum;
    logic signed [32:0] pd_shift;
    logic signed [32:0] total;

    always_comb begin
        p_term   = terms.p_term;
        d_term   = terms.d_term;
        i_ext    = terms.i_term;
        pd_sum   = p_term + d_term;
        pd_shift = $signed({pd_sum[19], pd_sum, {ptd_pkg::FRAC_BITS{1'b0}}});
        total    = pd_shift + i_ext;
        if (total[32] || (total == '0)) begin
            drive_percent = '0;
        end else if (total[31:ptd_pkg::FRAC_BITS] > 20'(ptd_pkg::PERCENT_FULL)) begin
            drive_percent = ptd_pkg::PERCENT_FULL;
        end else begin
            drive_percent = total[ptd_pkg::FRAC_BITS+6:ptd_pkg::FRAC_BITS];
        end
    end

endmodule
`default_nettype wire

[rtl/pid_temperature_duty.sv]
// pid temperature controller, sample pair in, heater pwm duty out
// six stage pipeline (input, error, gain products, drive, duty product, duty)
// throughput: one word per cycle; a stall at the output fills pipeline bubbles first
// reset (aresetn low, synchronous): pipeline empty, integral and previous error zero,
// registers at their reset values
`default_nettype none
module pid_temperature_duty (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // measured_sample[9:0], setpoint_sample[19:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // pwm_duty[9:0], drive_percent[16:10]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  kp_reg;
    logic [11:0] ki_q12_reg;
    logic [7:0]  kd_reg;
    logic [14:0] windup_limit_reg;
    logic [9:0]  duty_full_reg;

    logic [5:0] valid_reg;
    logic [5:0] valid_in;
    logic [5:0] stage_ready;

    logic [9:0]       meas0_reg;
    logic [9:0]       setp0_reg;
    ptd_pkg::error_t  err_next;
    ptd_pkg::error_t  err1_reg;
    ptd_pkg::terms_t  terms_next;
    ptd_pkg::terms_t  terms2_reg;
    logic [6:0]       drive_next;
    logic [6:0]       drive3_reg;
    logic [16:0]      prod4_next;
    logic [16:0]      prod4_reg;
    logic [6:0]       drive4_reg;
    logic [34:0]      duty_prod;
    logic [9:0]       duty5_reg;
    logic [6:0]       drive5_reg;

    logic cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg           <= ptd_pkg::KP_RESET;
            ki_q12_reg       <= ptd_pkg::KI_Q12_RESET;
            kd_reg           <= ptd_pkg::KD_RESET;
            windup_limit_reg <= ptd_pkg::WINDUP_LIMIT_RESET;
            duty_full_reg    <= ptd_pkg::DUTY_FULL_RESET;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                ptd_pkg::REG_KP:           kp_reg           <= pwdata[7:0];
                ptd_pkg::REG_KI_Q12:       ki_q12_reg       <= pwdata[11:0];
                ptd_pkg::REG_KD:           kd_reg           <= pwdata[7:0];
                ptd_pkg::REG_WINDUP_LIMIT: windup_limit_reg <= pwdata[14:0];
                ptd_pkg::REG_DUTY_FULL:    duty_full_reg    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            ptd_pkg::REG_KP:           prdata = {24'd0, kp_reg};
            ptd_pkg::REG_KI_Q12:       prdata = {20'd0, ki_q12_reg};
            ptd_pkg::REG_KD:           prdata = {24'd0, kd_reg};
            ptd_pkg::REG_WINDUP_LIMIT: prdata = {17'd0, windup_limit_reg};
            ptd_pkg::REG_DUTY_FULL:    prdata = {22'd0, duty_full_reg};
            default:                   prdata = '0;
        endcase
    end

    // pipeline flow control, each stage takes a word when it is empty or moving on
    always_comb begin
        stage_ready[5] = !valid_reg[5] || m_tready;
        for (int k = 4; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_in = {valid_reg[4:0], s_tvalid};
    assign s_tready = stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < 6; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    ptd_scale u_scale (
        .measured_sample (meas0_reg),
        .setpoint_sample (setp0_reg),
        .error_pct       (err_next)
    );

    ptd_law u_law (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .error_pct    (err1_reg),
        .update       (valid_reg[1] && stage_ready[2]),
        .kp           (kp_reg),
        .ki_q12       (ki_q12_reg),
        .kd           (kd_reg),
        .windup_limit (windup_limit_reg),
        .terms        (terms_next)
    );

    ptd_drive u_drive (
        .terms         (terms2_reg),
        .drive_percent (drive_next)
    );

    assign prod4_next = 17'(duty_full_reg) * 17'(drive3_reg);
    assign duty_prod  = 35'(prod4_reg) * ptd_pkg::DUTY_RECIP;

    always_ff @(posedge aclk) begin
        if (stage_ready[0] && valid_in[0]) begin
            meas0_reg <= s_tdata[9:0];
            setp0_reg <= s_tdata[19:10];
        end
        if (stage_ready[1] && valid_in[1]) begin
            err1_reg <= err_next;
        end
        if (stage_ready[2] && valid_in[2]) begin
            terms2_reg <= terms_next;
        end
        if (stage_ready[3] && valid_in[3]) begin
            drive3_reg <= drive_next;
        end
        if (stage_ready[4] && valid_in[4]) begin
            prod4_reg  <= prod4_next;
            drive4_reg <= drive3_reg;
        end
        if (stage_ready[5] && valid_in[5]) begin
            duty5_reg  <= duty_prod[ptd_pkg::DUTY_SHIFT+9:ptd_pkg::DUTY_SHIFT];
            drive5_reg <= drive4_reg;
        end
    end

    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {7'd0, drive5_reg, duty5_reg};

endmodule
`default_nettype wire

[rtl/ptd_checker.sv]
// port level checks for pid_temperature_duty, attached by bind
// depends on pid_temperature_duty port list
`default_nettype none
module ptd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // drive stays within percent range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:10] <= 7'd100)
        else $error("drive above full scale");

    // zero drive gives zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[16:10] == 7'd0) |-> m_tdata[9:0] == 10'd0)
        else $error("duty nonzero at zero drive");

    // empty output stage means the pipeline can take a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind pid_temperature_duty ptd_checker u_ptd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[bench/pid_temperature_duty_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for pid_temperature_duty: sample pairs on the s_ stream,
// duty words checked on the m_ stream against an in-bench controller model
// depends on rtl/ptd_pkg.sv and rtl/pid_temperature_duty.sv
module pid_temperature_duty_tb;

    localparam int ZERO_CODE      = 205;
    localparam int SPAN_CODES     = 409;
    localparam int PERCENT_SPAN   = 100;
    localparam int INTEGRAL_MAX   = 32767;
    localparam int INTEGRAL_MIN   = -32768;
    localparam int IDLE_PERCENT   = 36;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [6:0] drive_percent;
        logic [9:0] pwm_duty;
    } duty_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // measured_sample[9:0], setpoint_sample[19:10]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // pwm_duty[9:0], drive_percent[16:10]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // controller copy kept by the bench
    logic [7:0]  gain_p       = ptd_pkg::KP_RESET;
    logic [11:0] gain_i_q12   = ptd_pkg::KI_Q12_RESET;
    logic [7:0]  gain_d       = ptd_pkg::KD_RESET;
    logic [14:0] windup_bound = ptd_pkg::WINDUP_LIMIT_RESET;
    logic [9:0]  duty_scale   = ptd_pkg::DUTY_FULL_RESET;
    int          integral_sum = 0;
    int          last_error   = 0;

    duty_word_t  pending_duty[$];
    bit          no_idle      = 1'b0;
    bit          sat_upward;
    int          mismatches   = 0;
    int          pairs_sent   = 0;
    int          words_seen   = 0;
    int          reg_writes   = 0;
    int          stall_cycles = 0;

    pid_temperature_duty i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    function automatic int code_to_percent(input logic [9:0] code);
        return (PERCENT_SPAN * (int'(code) - ZERO_CODE)) / SPAN_CODES;
    endfunction

    function automatic duty_word_t predict_duty(input logic [9:0] meas, input logic [9:0] setp);
        duty_word_t word;
        int         err;
        int         mag;
        int         next_sum;
        int         drive;
        longint     total;
        err = code_to_percent(setp) - code_to_percent(meas);
        mag = (integral_sum < 0) ? -integral_sum : integral_sum;
        if (mag < int'(windup_bound)) begin
            next_sum = integral_sum + err;
            if (next_sum > INTEGRAL_MAX) next_sum = INTEGRAL_MAX;
            if (next_sum < INTEGRAL_MIN) next_sum = INTEGRAL_MIN;
            integral_sum = next_sum;
        end
        total = longint'(gain_p) * err * 4096
              + longint'(gain_i_q12) * integral_sum
              + longint'(gain_d) * (err - last_error) * 4096;
        if (total <= 0) begin
            drive = 0;
        end else if ((total >>> ptd_pkg::FRAC_BITS) > PERCENT_SPAN) begin
            drive = PERCENT_SPAN;
        end else begin
            drive = int'(total >>> ptd_pkg::FRAC_BITS);
        end
        last_error = err;
        word.drive_percent = drive[6:0];
        word.pwm_duty      = 10'((int'(duty_scale) * drive) / PERCENT_SPAN);
        return word;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        duty_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_duty.size() == 0) begin
                note_mismatch("unexpected word", -1, int'(m_tdata));
            end else begin
                want = pending_duty.pop_front();
                if (m_tdata[9:0] != want.pwm_duty)
                    note_mismatch("pwm_duty", int'(want.pwm_duty), int'(m_tdata[9:0]));
                if (m_tdata[16:10] != want.drive_percent)
                    note_mismatch("drive_percent", int'(want.drive_percent),
                                  int'(m_tdata[16:10]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("[pid_temperature_duty] ERROR");
            $finish;
        end
    end

    task automatic send_sample_pair(input logic [9:0] meas, input logic [9:0] setp);
        @(negedge aclk);
        while (!no_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, setp, meas};
        do @(posedge aclk); while (!s_tready);
        pending_duty.push_back(predict_duty(meas, setp));
        pairs_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            ptd_pkg::REG_KP:           gain_p       = value[7:0];
            ptd_pkg::REG_KI_Q12:       gain_i_q12   = value[11:0];
            ptd_pkg::REG_KD:           gain_d       = value[7:0];
            ptd_pkg::REG_WINDUP_LIMIT: windup_bound = value[14:0];
            ptd_pkg::REG_DUTY_FULL:    duty_scale   = value[9:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int kp, input int ki, input int kd, input int windup,
                             input int full);
        wait_for_results();
        write_register(ptd_pkg::REG_KP, kp);
        write_register(ptd_pkg::REG_KI_Q12, ki);
        write_register(ptd_pkg::REG_KD, kd);
        write_register(ptd_pkg::REG_WINDUP_LIMIT, windup);
        write_register(ptd_pkg::REG_DUTY_FULL, full);
    endtask

    // reset gains: code range ends, offset edge, truncation of negative percents
    task automatic test_sample_extremes();
        send_sample_pair(10'd0, 10'd0);
        send_sample_pair(10'd1023, 10'd1023);
        send_sample_pair(10'd0, 10'd1023);
        send_sample_pair(10'd1023, 10'd0);
        send_sample_pair(10'd205, 10'd205);
        send_sample_pair(10'd204, 10'd206);
        send_sample_pair(10'd206, 10'd204);
        send_sample_pair(10'd614, 10'd205);
        send_sample_pair(10'd205, 10'd614);
        send_sample_pair(10'h155, 10'h2aa);
        send_sample_pair(10'h2aa, 10'h155);
        send_sample_pair(10'd300, 10'd320);
        send_sample_pair(10'd320, 10'd300);
    endtask

    task automatic test_gain_extremes();
        configure(255, 4095, 255, 30000, 1023);
        send_sample_pair(10'd205, 10'd1023);
        send_sample_pair(10'd1023, 10'd205);
        send_sample_pair(10'd400, 10'd410);
    endtask

    // all gains zero, then zero duty scale with integration frozen
    task automatic test_zero_settings();
        configure(0, 0, 0, 30000, 1023);
        send_sample_pair(10'd0, 10'd1023);
        configure(int'(ptd_pkg::KP_RESET), int'(ptd_pkg::KI_Q12_RESET),
                  int'(ptd_pkg::KD_RESET), 0, 0);
        send_sample_pair(10'd300, 10'd600);
        send_sample_pair(10'd600, 10'd300);
        send_sample_pair(10'd300, 10'd600);
    endtask

    task automatic test_random_control();
        int        delta;
        int        meas_code;
        logic [9:0] setp;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                configure(int'(ptd_pkg::KP_RESET), int'(ptd_pkg::KI_Q12_RESET),
                          int'(ptd_pkg::KD_RESET), int'(ptd_pkg::WINDUP_LIMIT_RESET),
                          int'(ptd_pkg::DUTY_FULL_RESET));
            end else begin
                configure($urandom_range(1) ? $urandom_range(0, 30) : $urandom_range(0, 255),
                          $urandom_range(0, 4095),
                          $urandom_range(1) ? $urandom_range(0, 60) : $urandom_range(0, 255),
                          $urandom_range(0, 30000), $urandom_range(0, 1023));
            end
            no_idle = (phase == 2);
            repeat (35) begin
                setp = 10'($urandom_range(0, 1023));
                if ($urandom_range(99) < 60) begin
                    // measurement tracking the setpoint closely
                    delta     = int'($urandom_range(0, 80)) - 40;
                    meas_code = int'(setp) + delta;
                    if (meas_code < 0) meas_code = 0;
                    if (meas_code > 1023) meas_code = 1023;
                    send_sample_pair(10'(meas_code), setp);
                end else begin
                    send_sample_pair(10'($urandom_range(0, 1023)), setp);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // integral pushed past the 16-bit range in one direction, then probed near zero drive
    task automatic test_integral_saturation();
        logic [9:0] far_code;
        logic [9:0] zero_code;
        sat_upward = 1'($urandom_range(1));
        configure(0, 4095, 0, 32767, 1023);
        repeat (170) begin
            far_code  = 10'($urandom_range(980, 1023));
            zero_code = 10'($urandom_range(0, 100));
            if (sat_upward) send_sample_pair(zero_code, far_code);
            else send_sample_pair(far_code, zero_code);
        end
        configure(164, 4095, 1, 32767, 1023);
        repeat (40) begin
            far_code  = 10'($urandom_range(1010, 1023));
            zero_code = 10'($urandom_range(195, 215));
            if (sat_upward) send_sample_pair(far_code, zero_code);
            else send_sample_pair(zero_code, far_code);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_sample_extremes();
        test_gain_extremes();
        test_zero_settings();
        test_random_control();
        test_integral_saturation();
        wait_for_results();
        $display("sent %0d sample pairs, checked %0d duty words, %0d register writes",
                 pairs_sent, words_seen, reg_writes);
        $display("gain extremes, zero gains and duty, frozen and %s saturated integral",
                 sat_upward ? "upward" : "downward");
        if (mismatches == 0) begin
            $display("[pid_temperature_duty] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[pid_temperature_duty] ERROR");
        end
        $finish;
    end

endmodule
